// ----- hw/rtl/gdt_pkg.sv -----
package gdt_pkg;

  // One date and time to convert.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
  } item_t;

  // One conversion result.
  typedef struct packed {
    logic [61:0] tick_count;
    logic [2:0]  error_code;
  } result_t;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_DATE = 3'd1;
  localparam logic [2:0] ERR_DAY  = 3'd2;
  localparam logic [2:0] ERR_TIME = 3'd3;
  localparam logic [2:0] ERR_MSEC = 3'd4;

  localparam int unsigned MAX_YEAR     = 9999;
  localparam int unsigned DAYS_YEAR    = 365;
  localparam int unsigned HOURS_DAY    = 24;
  localparam int unsigned MINS_HOUR    = 60;
  localparam int unsigned MS_SECOND    = 1000;
  localparam int unsigned MS_MINUTE    = 60000;
  localparam int unsigned MS_HOUR      = 3600000;
  localparam int unsigned MS_DAY       = 86400000;
  localparam int unsigned TICKS_MS     = 10000;
  localparam int unsigned CENTURY      = 100;

  // x / 100 == (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x.
  localparam int unsigned RECIP_100    = 5243;
  localparam int unsigned RECIP_SHIFT  = 19;

  localparam logic [61:0] MAX_TICKS = 62'd3155378975999999999;

  // Days in the year before the first day of the month.
  function automatic logic [8:0] days_before(input logic [3:0] month, input logic leap);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && (month > 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    case (month)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/gregorian_date_to_ticks_top.sv -----
// Channel   Direction  Handshake          Payload
// item      in         start, busy        gdt_pkg::item_t
// result    out        done (strobe)      gdt_pkg::result_t
//
// One item is taken per cycle. Each item passes through five register stages in order:
// range checks, calendar lookup, day count, milliseconds of the epoch, and the
// scaling to ticks.
// Reset empties the pipeline; busy is high only while reset is held.
// The receiver cannot stall, so busy never rises in operation.
module gregorian_date_to_ticks_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  gdt_pkg::item_t    item,
  output logic              done,
  output gdt_pkg::result_t  result
);
  import gdt_pkg::*;

  // Stage 1: range checks, year - 1 and its quotient by 100.
  logic        s1_valid;
  logic [13:0] s1_y;
  logic [7:0]  s1_q;
  logic [3:0]  s1_month;
  logic [4:0]  s1_day;
  logic [4:0]  s1_hour;
  logic [5:0]  s1_minute;
  logic [5:0]  s1_second;
  logic [9:0]  s1_msec;
  logic        s1_date_bad;
  logic        s1_time_bad;
  logic        s1_msec_bad;

  // Stage 2: leap year, month table, final error code.
  logic        s2_valid;
  logic [13:0] s2_y;
  logic [7:0]  s2_q;
  logic [8:0]  s2_dbm;
  logic [4:0]  s2_day;
  logic [4:0]  s2_hour;
  logic [5:0]  s2_minute;
  logic [5:0]  s2_second;
  logic [9:0]  s2_msec;
  logic [2:0]  s2_err;

  // Stage 3: day number and millisecond of the day.
  logic        s3_valid;
  logic [22:0] s3_days;
  logic [26:0] s3_msday;
  logic [2:0]  s3_err;

  // Stage 4: milliseconds since the epoch.
  logic        s4_valid;
  logic [48:0] s4_ms;
  logic [2:0]  s4_err;

  // Stage 5: output register.
  logic        s5_valid;
  result_t     s5_result;

  logic        accept;
  logic [13:0] y_in;
  logic [26:0] q_prod;
  logic [13:0] rem;
  logic        leap;
  logic [4:0]  mlen;
  logic [2:0]  err_next;
  logic [23:0] days_sum;
  logic [48:0] ms_sum;
  logic [61:0] ticks;

  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = s5_valid;
  assign result = s5_result;

  assign y_in   = item.year - 14'd1;
  assign q_prod = 27'(y_in) * 27'(RECIP_100);

  // Leap test on year - 1: year % 4 == 0 is y % 4 == 3, and so on for 100 and 400.
  assign rem  = 14'(15'(s1_y) - 15'(s1_q) * 15'(CENTURY));
  assign leap = (s1_y[1:0] == 2'd3) && ((rem != 14'(CENTURY - 1)) || (s1_q[1:0] == 2'd3));
  assign mlen = month_days(s1_month, leap);

  always_comb begin
    if (s1_date_bad) begin
      err_next = ERR_DATE;
    end else if (s1_day > mlen) begin
      err_next = ERR_DAY;
    end else if (s1_time_bad) begin
      err_next = ERR_TIME;
    end else if (s1_msec_bad) begin
      err_next = ERR_MSEC;
    end else begin
      err_next = ERR_NONE;
    end
  end

  assign days_sum = 24'(s2_y) * 24'(DAYS_YEAR) + 24'(s2_y >> 2) - 24'(s2_q)
                  + 24'(s2_q >> 2) + 24'(s2_dbm) + 24'(s2_day) - 24'd1;

  assign ms_sum = 49'(s3_days) * 49'(MS_DAY) + 49'(s3_msday);
  assign ticks  = 62'(s4_ms) * 62'(TICKS_MS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_y        <= y_in;
    s1_q        <= q_prod[26:RECIP_SHIFT];
    s1_month    <= item.month;
    s1_day      <= item.day;
    s1_hour     <= item.hour;
    s1_minute   <= item.minute;
    s1_second   <= item.second;
    s1_msec     <= item.millisecond;
    s1_date_bad <= (item.year == 14'd0) || (item.year > 14'(MAX_YEAR)) ||
                   (item.month == 4'd0) || (item.month > 4'd12) || (item.day == 5'd0);
    s1_time_bad <= (item.hour >= 5'(HOURS_DAY)) || (item.minute >= 6'(MINS_HOUR)) ||
                   (item.second >= 6'(MINS_HOUR));
    s1_msec_bad <= item.millisecond >= 10'(MS_SECOND);

    s2_y      <= s1_y;
    s2_q      <= s1_q;
    s2_dbm    <= days_before(s1_month, leap);
    s2_day    <= s1_day;
    s2_hour   <= s1_hour;
    s2_minute <= s1_minute;
    s2_second <= s1_second;
    s2_msec   <= s1_msec;
    s2_err    <= err_next;

    s3_days  <= days_sum[22:0];
    s3_msday <= 27'(s2_hour) * 27'(MS_HOUR) + 27'(s2_minute) * 27'(MS_MINUTE)
              + 27'(s2_second) * 27'(MS_SECOND) + 27'(s2_msec);
    s3_err   <= s2_err;

    s4_ms  <= ms_sum;
    s4_err <= s3_err;

    s5_result.tick_count <= (s4_err == ERR_NONE) ? ticks : 62'd0;
    s5_result.error_code <= s4_err;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted item did not produce a result after five cycles");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.error_code != ERR_NONE)) |-> (result.tick_count == 62'd0))
    else $error("nonzero tick count with an error code");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.error_code == ERR_NONE || result.error_code == ERR_DATE ||
              result.error_code == ERR_DAY || result.error_code == ERR_TIME ||
              result.error_code == ERR_MSEC))
    else $error("undefined error code");

  a_max_ticks: assert property (@(posedge clk) disable iff (rst)
    (done && (result.error_code == ERR_NONE)) |-> (result.tick_count <= MAX_TICKS))
    else $error("tick count beyond the last representable instant");
`endif

endmodule

// ----- tb/sv/tb_gregorian_date_to_ticks_top.sv -----
module tb_gregorian_date_to_ticks_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gdt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 360;
  localparam int unsigned SETTLE_TIME  = 20;
  localparam int unsigned MAX_GAP      = 60;

  localparam int unsigned DAYS_AHEAD [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                               304, 334, 365};

  localparam longint unsigned T_MS   = 64'd10000;
  localparam longint unsigned T_SEC  = 64'd10000000;
  localparam longint unsigned T_MIN  = 64'd600000000;
  localparam longint unsigned T_HOUR = 64'd36000000000;
  localparam longint unsigned T_DAY  = 64'd864000000000;

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Month must already be in 1..12.
  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    int unsigned n;
    n = DAYS_AHEAD[m] - DAYS_AHEAD[m - 1];
    if (m == 2 && is_leap_year(y)) begin
      n = n + 1;
    end
    return n;
  endfunction

  class tick_scoreboard;
    result_t due_results[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function result_t date_ticks(input item_t it);
      result_t r;
      int unsigned y;
      int unsigned days;
      longint unsigned ticks;
      r = '0;
      if (it.year < 1 || it.year > MAX_YEAR || it.month < 1 || it.month > 12 ||
          it.day < 1) begin
        r.error_code = ERR_DATE;
      end else if (it.day > days_in_month(32'(it.year), 32'(it.month))) begin
        r.error_code = ERR_DAY;
      end else if (it.hour >= HOURS_DAY || it.minute >= MINS_HOUR ||
                   it.second >= MINS_HOUR) begin
        r.error_code = ERR_TIME;
      end else if (it.millisecond >= MS_SECOND) begin
        r.error_code = ERR_MSEC;
      end else begin
        y = it.year - 1;
        days = y * DAYS_YEAR + y / 4 - y / 100 + y / 400 + DAYS_AHEAD[it.month - 1] +
               it.day - 1;
        if (it.month > 2 && is_leap_year(32'(it.year))) begin
          days = days + 1;
        end
        ticks = longint'(days) * T_DAY + longint'(it.hour) * T_HOUR +
                longint'(it.minute) * T_MIN + longint'(it.second) * T_SEC +
                longint'(it.millisecond) * T_MS;
        r.tick_count = ticks[61:0];
        r.error_code = ERR_NONE;
      end
      return r;
    endfunction

    function void note_item(input item_t it);
      due_results.push_back(date_ticks(it));
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: tick_count %0d error_code %0d",
               got.tick_count, got.error_code);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (got.tick_count !== want.tick_count) begin
          $error("tick_count: expected %0d, got %0d", want.tick_count, got.tick_count);
          mismatches++;
        end
        if (got.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    done;
  result_t result;

  tick_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;

  gregorian_date_to_ticks_top u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Inputs change only through nonblocking assignments, so at each edge these
  // reads see the values that the block itself acts on.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        sb.check_result(result);
      end
      if (start && !busy) begin
        sb.note_item(item);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_gregorian_date_to_ticks_top failed");
      $finish;
    end
  end

  function automatic item_t make_item(input int unsigned y, input int unsigned mo,
                                      input int unsigned d, input int unsigned h,
                                      input int unsigned mi, input int unsigned s,
                                      input int unsigned ms);
    item_t it;
    it.year        = y[13:0];
    it.month       = mo[3:0];
    it.day         = d[4:0];
    it.hour        = h[4:0];
    it.minute      = mi[5:0];
    it.second      = s[5:0];
    it.millisecond = ms[9:0];
    return it;
  endfunction

  function automatic item_t valid_item();
    item_t it;
    int unsigned y;
    int unsigned mo;
    y  = ($urandom_range(3) == 0) ? $urandom_range(99) * 100 + 100 : $urandom_range(1, 9999);
    if (y > MAX_YEAR) begin
      y = MAX_YEAR;
    end
    mo = $urandom_range(1, 12);
    it = make_item(y, mo, $urandom_range(1, days_in_month(y, mo)), $urandom_range(23),
                   $urandom_range(59), $urandom_range(59), $urandom_range(999));
    if ($urandom_range(7) == 0) begin
      it.day = 5'(days_in_month(y, mo));
    end
    return it;
  endfunction

  // A well-formed date and time with exactly one field pushed out of range.
  function automatic item_t broken_item();
    item_t it;
    int unsigned dim;
    it = valid_item();
    dim = days_in_month(32'(it.year), 32'(it.month));
    case ($urandom_range(6))
      0: it.day = (dim == 31) ? 5'd0 : 5'(dim + 1);
      1: it.month = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
      2: it.year = ($urandom_range(1) == 0) ? 14'd0 : 14'($urandom_range(10000, 16383));
      3: it.hour = 5'($urandom_range(24, 31));
      4: it.minute = 6'($urandom_range(60, 63));
      5: it.second = 6'($urandom_range(60, 63));
      default: it.millisecond = 10'($urandom_range(1000, 1023));
    endcase
    return it;
  endfunction

  function automatic item_t random_item();
    int unsigned pick;
    logic [63:0] raw;
    pick = $urandom_range(99);
    if (pick < 65) begin
      return valid_item();
    end else if (pick < 85) begin
      return broken_item();
    end
    raw = {$urandom, $urandom};
    return item_t'(raw[$bits(item_t)-1:0]);
  endfunction

  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Hold off new transfers until every pending conversion has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    item_t directed[$];
    int unsigned phase_pct[4];
    phase_pct = '{0, 84, 0, 26};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(make_item(1, 1, 1, 0, 0, 0, 0));
    directed.push_back(make_item(9999, 12, 31, 23, 59, 59, 999));
    directed.push_back(make_item(0, 6, 15, 12, 30, 30, 500));
    directed.push_back(make_item(10000, 1, 1, 0, 0, 0, 0));
    directed.push_back(make_item(16383, 15, 31, 31, 63, 63, 1023));
    directed.push_back(make_item(2020, 0, 10, 1, 2, 3, 4));
    directed.push_back(make_item(2020, 13, 10, 1, 2, 3, 4));
    directed.push_back(make_item(2020, 15, 10, 1, 2, 3, 4));
    directed.push_back(make_item(2020, 5, 0, 1, 2, 3, 4));
    directed.push_back(make_item(2000, 2, 29, 6, 7, 8, 9));
    directed.push_back(make_item(1900, 2, 29, 6, 7, 8, 9));
    directed.push_back(make_item(2024, 2, 29, 0, 0, 0, 0));
    directed.push_back(make_item(2023, 2, 29, 0, 0, 0, 0));
    directed.push_back(make_item(2023, 4, 31, 0, 0, 0, 0));
    directed.push_back(make_item(2023, 1, 31, 23, 59, 59, 999));
    directed.push_back(make_item(2023, 3, 1, 24, 0, 0, 0));
    directed.push_back(make_item(2023, 3, 1, 31, 0, 0, 0));
    directed.push_back(make_item(2023, 3, 1, 0, 60, 0, 0));
    directed.push_back(make_item(2023, 3, 1, 0, 63, 0, 0));
    directed.push_back(make_item(2023, 3, 1, 0, 0, 60, 0));
    directed.push_back(make_item(2023, 3, 1, 0, 0, 63, 0));
    directed.push_back(make_item(2023, 3, 1, 0, 0, 0, 1000));
    directed.push_back(make_item(2023, 3, 1, 0, 0, 0, 1023));
    // Several faults at once: the earliest check decides the code.
    directed.push_back(make_item(0, 2, 31, 31, 63, 63, 1023));
    directed.push_back(make_item(2023, 2, 30, 24, 60, 60, 1000));
    directed.push_back(make_item(2023, 7, 4, 24, 0, 0, 1000));

    foreach (directed[i]) begin
      send_item(directed[i]);
    end
    drain();

    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      repeat (PHASE_ITEMS) begin
        send_item(random_item());
      end
      drain();
    end

    repeat (SETTLE_TIME) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("tb_gregorian_date_to_ticks_top passed");
    end else begin
      $display("tb_gregorian_date_to_ticks_top failed");
    end
    $finish;
  end

endmodule
